// File: hdl/ipu_pkg.sv
package ipu_pkg;

  // Fixed field widths of the channels and the configuration port
  localparam int KIND_W      = 1;
  localparam int WORD_W      = 32;
  localparam int INDEX_W     = 12;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;

  // Parameter defaults
  localparam int STORE_DEPTH_DEF = 4096;
  localparam int DATA_WIDTH_DEF  = 32;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
  localparam logic [KIND_W-1:0] KIND_EMIT = 1'b1;

  // Response status codes
  localparam logic [STATUS_W-1:0] STATUS_VALID = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BATCH_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_HEIGHT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_WIDTH  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC1,
    ST_CALC2,
    ST_CALC3,
    ST_READ,
    ST_RESP
  } ipu_state_t;

endpackage

// File: hdl/ipu_channels.sv
interface ipu_req_if;
  import ipu_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [WORD_W-1:0] data_word;

  modport source (output valid, output kind, output data_word, input ready);
  modport sink   (input valid, input kind, input data_word, output ready);
endinterface

interface ipu_rsp_if;
  import ipu_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   element;
  logic [INDEX_W-1:0]  patch_row;
  logic [INDEX_W-1:0]  matrix_column;
  logic                is_last;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output element, output patch_row, output matrix_column,
                  output is_last, output status, input ready);
  modport sink   (input valid, input element, input patch_row, input matrix_column,
                  input is_last, input status, output ready);
endinterface

// File: hdl/ipu_store.sv
module ipu_store #(
  parameter int DEPTH = ipu_pkg::STORE_DEPTH_DEF,
  parameter int WIDTH = ipu_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  import ipu_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/im2col_patch_unroller_core.sv
// im2col patch unroller: valid convolution, stride 1, no padding.
// Channel req (sink) carries one word per request: kind selects a load, which
// writes data_word into the tensor store at the load pointer, or an emit,
// which asks for the next element of the im2col matrix in row-major order.
// Channel rsp (source) returns one word per emit with the element, its
// matrix row and column, a last-element mark and a status (valid, nothing
// left, or configuration/capacity error). Loads return nothing.
// The cfg port writes the six shape registers; a write to any of them restarts the load
// pointer and the emit position and clears the error flag.
// Throughput: loads stream at one per cycle while no emit is under way.
// An emit holds req not ready from its acceptance until it leaves ST_RESP:
// ST_CALC1 to ST_CALC3 do the address arithmetic (one multiply per stage),
// ST_READ does the store's registered read, and ST_RESP hands the word to
// the rsp register. No new load or emit is taken before then.
// The result word is registered into rsp as the emit leaves ST_RESP.
// Reset restores the register defaults (1x1x8x8 tensor, 3x3 kernel) and
// clears all positions and flags; store contents stay undefined until loaded.
// When rsp stalls, the finished word waits in the rsp register; the block
// still takes loads and starts the next emit, which then holds in its last
// step until the rsp register frees up.
module im2col_patch_unroller_core #(
  parameter int STORE_DEPTH = ipu_pkg::STORE_DEPTH_DEF,
  parameter int DATA_WIDTH  = ipu_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ipu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ipu_pkg::CFG_DATA_W-1:0]   cfg_data,
  ipu_req_if.sink                          req,
  ipu_rsp_if.source                        rsp
);
  import ipu_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int PTR_W = $clog2(STORE_DEPTH + 1);
  localparam int T1_W  = 12;   // batch*C + channel
  localparam int T2_W  = 20;   // (...)*H + row
  localparam int A_W   = 27;   // (...)*W + column
  localparam int TOT_W = 26;   // B*C*H*W

  // Shape registers
  logic [4:0] batch_count;
  logic [6:0] channel_count;
  logic [6:0] image_height;
  logic [6:0] image_width;
  logic [3:0] kernel_height;
  logic [3:0] kernel_width;

  // Load and emit position state
  logic [PTR_W-1:0] load_pointer;
  logic [3:0]       batch_pos, batch_pos_next;
  logic [5:0]       out_row_pos, out_row_pos_next;
  logic [5:0]       out_col_pos, out_col_pos_next;
  logic [5:0]       channel_pos, channel_pos_next;
  logic [2:0]       kernel_row_pos, kernel_row_pos_next;
  logic [2:0]       kernel_col_pos, kernel_col_pos_next;
  logic             finished;
  logic             error_flag;

  // Shape check pipeline
  logic [11:0]      prod_bc;
  logic [13:0]      prod_hw;
  logic [TOT_W-1:0] total;
  logic             cfg_ok;
  logic             shape_in_range;

  // Emit arithmetic stages
  logic [T1_W-1:0]    t1;
  logic [T2_W-1:0]    t2;
  logic [A_W-1:0]     addr;
  logic [6:0]         row_sum;
  logic [6:0]         col_sum;
  logic [INDEX_W-1:0] row_part;
  logic [INDEX_W-1:0] col_part;
  logic [INDEX_W-1:0] row_idx;
  logic [INDEX_W-1:0] col_idx;
  logic [STATUS_W-1:0] status_q;
  logic               last_q;

  logic [6:0] oh_n;
  logic [6:0] ow_n;
  logic       is_last_pos;

  ipu_state_t state, state_next;

  logic                  cfg_hit;
  logic                  load_fire;
  logic                  load_room;
  logic                  rd_en;
  logic                  resp_fire;
  logic [DATA_WIDTH-1:0] rd_data;

  assign cfg_hit   = cfg_we && (cfg_index <= REG_KERNEL_WIDTH);
  assign load_fire = req.valid && req.ready && (req.kind == KIND_LOAD);
  assign load_room = (load_pointer != PTR_W'(STORE_DEPTH));

  // Output size of the valid convolution
  assign oh_n = image_height - {3'b000, kernel_height} + 7'd1;
  assign ow_n = image_width - {3'b000, kernel_width} + 7'd1;

  ipu_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_fire && load_room),
    .wr_addr (load_pointer[AW-1:0]),
    .wr_data (DATA_WIDTH'(req.data_word)),
    .rd_en   (rd_en),
    .rd_addr (addr[AW-1:0]),
    .rd_data (rd_data)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_count   <= 5'd1;
      channel_count <= 7'd1;
      image_height  <= 7'd8;
      image_width   <= 7'd8;
      kernel_height <= 4'd3;
      kernel_width  <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BATCH_COUNT:   batch_count   <= cfg_data[4:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[3:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Shape check: two product stages, then a registered compare. An emit accepted
  // together with a write, or already under way, can still see the old result.
  assign shape_in_range =
      (batch_count >= 5'd1) && (batch_count <= 5'd16) &&
      (channel_count >= 7'd1) && (channel_count <= 7'd64) &&
      (image_height >= 7'd1) && (image_height <= 7'd64) &&
      (image_width >= 7'd1) && (image_width <= 7'd64) &&
      (kernel_height >= 4'd1) && (kernel_height <= 4'd8) &&
      (kernel_width >= 4'd1) && (kernel_width <= 4'd8) &&
      ({3'b000, kernel_height} <= image_height) &&
      ({3'b000, kernel_width} <= image_width);

  always_ff @(posedge clk) begin
    prod_bc <= 12'(batch_count) * 12'(channel_count);
    prod_hw <= 14'(image_height) * 14'(image_width);
    total   <= TOT_W'(prod_bc) * TOT_W'(prod_hw);
    cfg_ok  <= shape_in_range && (total <= TOT_W'(STORE_DEPTH));
  end

  // Load pointer and sticky error
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer <= '0;
      error_flag   <= 1'b0;
    end else if (cfg_hit) begin
      load_pointer <= '0;
      error_flag   <= 1'b0;
    end else if (load_fire) begin
      if (load_room) begin
        load_pointer <= load_pointer + PTR_W'(1);
      end else begin
        error_flag <= 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req.valid && (req.kind == KIND_EMIT)) state_next = ST_CALC1;
      ST_CALC1: state_next = ST_CALC2;
      ST_CALC2: state_next = ST_CALC3;
      ST_CALC3: state_next = ST_READ;
      ST_READ:  state_next = ST_RESP;
      ST_RESP:  if (!rsp.valid || rsp.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req.ready = 1'b0;
    rd_en     = 1'b0;
    resp_fire = 1'b0;
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_READ: rd_en     = 1'b1;
      ST_RESP: resp_fire = !rsp.valid || rsp.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Address, row and column arithmetic: one multiply per stage in each chain
  always_ff @(posedge clk) begin
    case (state)
      ST_CALC1: begin
        t1       <= T1_W'(batch_pos) * T1_W'(channel_count) + T1_W'(channel_pos);
        row_sum  <= 7'(out_row_pos) + 7'(kernel_row_pos);
        col_sum  <= 7'(out_col_pos) + 7'(kernel_col_pos);
        row_part <= INDEX_W'(batch_pos) * INDEX_W'(oh_n) + INDEX_W'(out_row_pos);
        col_part <= INDEX_W'(channel_pos) * INDEX_W'(kernel_height)
                    + INDEX_W'(kernel_row_pos);
      end
      ST_CALC2: begin
        t2      <= T2_W'(t1) * T2_W'(image_height) + T2_W'(row_sum);
        row_idx <= row_part * INDEX_W'(ow_n) + INDEX_W'(out_col_pos);
        col_idx <= col_part * INDEX_W'(kernel_width) + INDEX_W'(kernel_col_pos);
      end
      ST_CALC3: begin
        addr   <= A_W'(t2) * A_W'(image_width) + A_W'(col_sum);
        last_q <= is_last_pos;
        if (error_flag || !cfg_ok) begin
          status_q <= STATUS_ERROR;
        end else if (finished) begin
          status_q <= STATUS_EMPTY;
        end else begin
          status_q <= STATUS_VALID;
        end
      end
      default: ;
    endcase
  end

  assign is_last_pos =
      ({1'b0, batch_pos} == batch_count - 5'd1) &&
      ({1'b0, out_row_pos} == oh_n - 7'd1) &&
      ({1'b0, out_col_pos} == ow_n - 7'd1) &&
      ({1'b0, channel_pos} == channel_count - 7'd1) &&
      ({1'b0, kernel_row_pos} == kernel_height - 4'd1) &&
      ({1'b0, kernel_col_pos} == kernel_width - 4'd1);

  // Advance the emit position, innermost first: kernel column, kernel row,
  // channel, output column, output row, batch.
  always_comb begin
    batch_pos_next      = batch_pos;
    out_row_pos_next    = out_row_pos;
    out_col_pos_next    = out_col_pos;
    channel_pos_next    = channel_pos;
    kernel_row_pos_next = kernel_row_pos;
    kernel_col_pos_next = kernel_col_pos;
    if ({1'b0, kernel_col_pos} + 4'd1 < kernel_width) begin
      kernel_col_pos_next = kernel_col_pos + 3'd1;
    end else begin
      kernel_col_pos_next = '0;
      if ({1'b0, kernel_row_pos} + 4'd1 < kernel_height) begin
        kernel_row_pos_next = kernel_row_pos + 3'd1;
      end else begin
        kernel_row_pos_next = '0;
        if ({1'b0, channel_pos} + 7'd1 < channel_count) begin
          channel_pos_next = channel_pos + 6'd1;
        end else begin
          channel_pos_next = '0;
          if ({1'b0, out_col_pos} + 7'd1 < ow_n) begin
            out_col_pos_next = out_col_pos + 6'd1;
          end else begin
            out_col_pos_next = '0;
            if ({1'b0, out_row_pos} + 7'd1 < oh_n) begin
              out_row_pos_next = out_row_pos + 6'd1;
            end else begin
              out_row_pos_next = '0;
              batch_pos_next   = batch_pos + 4'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      batch_pos      <= '0;
      out_row_pos    <= '0;
      out_col_pos    <= '0;
      channel_pos    <= '0;
      kernel_row_pos <= '0;
      kernel_col_pos <= '0;
      finished       <= 1'b0;
    end else if (resp_fire && (status_q == STATUS_VALID)) begin
      if (last_q) begin
        finished <= 1'b1;
      end else begin
        batch_pos      <= batch_pos_next;
        out_row_pos    <= out_row_pos_next;
        out_col_pos    <= out_col_pos_next;
        channel_pos    <= channel_pos_next;
        kernel_row_pos <= kernel_row_pos_next;
        kernel_col_pos <= kernel_col_pos_next;
      end
    end
  end

  // Response register: hold the word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (resp_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_fire) begin
      rsp.status <= status_q;
      if (status_q == STATUS_VALID) begin
        rsp.element       <= WORD_W'(rd_data);
        rsp.patch_row     <= row_idx;
        rsp.matrix_column <= col_idx;
        rsp.is_last       <= last_q;
      end else begin
        rsp.element       <= '0;
        rsp.patch_row     <= '0;
        rsp.matrix_column <= '0;
        rsp.is_last       <= 1'b0;
      end
    end
  end

endmodule
